// ===== hw/rtl/ring_to_line_min_distance_macros.svh =====
// ring_to_line_min_distance_macros.svh: assertion macros for the RTL files.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef RING_TO_LINE_MIN_DISTANCE_MACROS_SVH
`define RING_TO_LINE_MIN_DISTANCE_MACROS_SVH
`ifndef ASSERT_OFF
`define RLMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RLMD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define RLMD_ASSERT(lbl, prop, msg)
`define RLMD_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== hw/rtl/rlmd_pkg.sv =====
`timescale 1ns / 1ps
// rlmd_pkg: widths, payload structs, codes and sequencer states shared by
// the ring-to-line distance block. No dependencies.
package rlmd_pkg;

  localparam int COORD_W         = 24;
  localparam int DIR_W           = 18;
  localparam int DIR_FRAC        = 16;
  localparam int TOL_W           = 16;
  localparam int VEC_W           = 27;
  localparam int ACC_W           = 64;
  localparam int MUL_W           = 34;
  localparam int HALF_W          = 32;
  localparam int SQ_W            = 50;
  localparam int ROOT_W          = 25;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 24;
  localparam int T_FRAC_BITS_DEF = 16;

  localparam logic signed [DIR_W-1:0] DIR_X_RST = DIR_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_DIR_X    = 3'd3,
    CFG_DIR_Y    = 3'd4,
    CFG_DIR_Z    = 3'd5,
    CFG_ZERO_TOL = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic signed [COORD_W-1:0] vz;
    logic                      ring_last;
  } rlmd_in_t;

  typedef struct packed {
    logic [SQ_W-1:0]   min_dist_sq;
    logic [ROOT_W-1:0] min_dist;
  } rlmd_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VEC,
    ST_DOT,
    ST_RND,
    ST_QUAD,
    ST_DECIDE,
    ST_DIV,
    ST_EVAL,
    ST_TAKE,
    ST_SQRT,
    ST_OUT
  } state_t;

  typedef enum logic {
    UM_DIV,
    UM_SQRT
  } unit_mode_t;

  typedef struct packed {
    logic       start;
    unit_mode_t mode;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

// ===== hw/rtl/rlmd_divsqrt.sv =====
`timescale 1ns / 1ps
// rlmd_divsqrt: shared bit-serial unit, restoring fraction divide or integer
// square root, one result bit per cycle. Depends on rlmd_pkg.
module rlmd_divsqrt import rlmd_pkg::*; #(
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  unit_ctl_t        ctl,
  input  logic [ACC_W-1:0] op_a,
  input  logic [ACC_W-1:0] op_b,
  output unit_sts_t        sts,
  output logic [ACC_W-1:0] res
);

  localparam int STEPS_MAX = (T_FRAC_BITS > ROOT_W) ? T_FRAC_BITS : ROOT_W;
  localparam int CNT_W     = $clog2(STEPS_MAX);
  localparam int B_W       = 2 * ROOT_W - 1;
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(T_FRAC_BITS - 1);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W - 1);
  localparam logic [B_W-1:0]   B_TOP     = {1'b1, {(B_W-1){1'b0}}};

  unit_mode_t       mode_r;
  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [ACC_W-1:0] rem_r;
  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] div_r;
  logic [B_W-1:0]   b_r;
  logic [ACC_W-1:0] cmp_a;
  logic [ACC_W-1:0] cmp_b;
  logic [ACC_W-1:0] diff;
  logic             ge;

  // one compare/subtract serves both modes
  always_comb begin
    if (mode_r == UM_DIV) begin
      cmp_a = {rem_r[ACC_W-2:0], 1'b0};
      cmp_b = div_r;
    end else begin
      cmp_a = rem_r;
      cmp_b = acc_r + ACC_W'(b_r);
    end
    ge   = (cmp_a >= cmp_b);
    diff = cmp_a - cmp_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      mode_r <= UM_DIV;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        mode_r <= ctl.mode;
        cnt_r  <= (ctl.mode == UM_DIV) ? DIV_LAST : SQRT_LAST;
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= op_a;
      div_r <= op_b;
      acc_r <= '0;
      b_r   <= B_TOP;
    end else if (busy_r) begin
      if (mode_r == UM_DIV) begin
        rem_r <= ge ? diff : cmp_a;
        acc_r <= {acc_r[ACC_W-2:0], ge};
      end else begin
        rem_r <= ge ? diff : rem_r;
        acc_r <= ge ? ((acc_r >> 1) + ACC_W'(b_r)) : (acc_r >> 1);
        b_r   <= b_r >> 2;
      end
    end
  end

  assign sts = '{busy: busy_r, done: done_r};
  assign res = acc_r;

endmodule

// ===== hw/rtl/ring_to_line_min_distance.sv =====
`timescale 1ns / 1ps
// Smallest squared distance from a closed polygon ring to a 3-D line; one
// vertex per request, ring_last closes the ring and yields one result request
// carrying the minimum and its integer root. A vertex that opens a ring and
// does not close it is only stored. Each edge runs through one shared 34x34
// multiplier (22 products) and, when the minimum falls inside the edge, the
// bit-serial divider for t. The last vertex handles its own edge and the
// closing edge, then a 25-step bit-serial square root in the same unit. A
// finished result waits in the output register while the next ring streams in.
// Depends on rlmd_pkg, rlmd_divsqrt and ring_to_line_min_distance_macros.svh.
`include "ring_to_line_min_distance_macros.svh"
module ring_to_line_min_distance import rlmd_pkg::*; #(
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rlmd_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rlmd_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int TW = T_FRAC_BITS + 1;
  localparam logic [TW-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};
  localparam logic signed [ACC_W-1:0] VEC_LIM = ACC_W'((64'd1 << (VEC_W - 1)) - 64'd1);
  localparam logic signed [ACC_W-1:0] SQ_MAX  = ACC_W'((64'd1 << SQ_W) - 64'd1);

  typedef enum logic [2:0] {
    DT_AA,
    DT_AE,
    DT_EE,
    DT_ADR,
    DT_EDR
  } dot_term_t;

  function automatic logic signed [VEC_W-1:0] sat_vec(input logic signed [COORD_W:0] x);
    logic signed [ACC_W-1:0] xe;
    xe = ACC_W'(x);
    if (xe > VEC_LIM) return VEC_W'(VEC_LIM);
    if (xe < -VEC_LIM) return VEC_W'(-VEC_LIM);
    return VEC_W'(xe);
  endfunction

  // Q.16 -> integer, to nearest, ties away from zero
  function automatic logic signed [MUL_W-1:0] round_dir(input logic signed [ACC_W-1:0] x);
    logic [ACC_W-1:0] m;
    m = x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
    m = (m + (ACC_W'(1) << (DIR_FRAC - 1))) >> DIR_FRAC;
    return x[ACC_W-1] ? -MUL_W'(m) : MUL_W'(m);
  endfunction

  state_t state_r, state_nxt;

  logic signed [COORD_W-1:0] org_r [3];
  logic signed [DIR_W-1:0]   dir_r [3];
  logic [TOL_W-1:0]          tol_r;

  logic signed [COORD_W-1:0] first_r [3];
  logic signed [COORD_W-1:0] prev_r [3];
  logic signed [COORD_W-1:0] vin [3];
  logic                      have_prev_r;
  logic                      have_best_r;
  logic                      last_r;
  logic                      close_r;
  logic [SQ_W-1:0]           best_r;

  logic signed [COORD_W-1:0] p0_r [3];
  logic signed [COORD_W-1:0] p1_r [3];
  logic signed [VEC_W-1:0]   a_r [3];
  logic signed [VEC_W-1:0]   e_r [3];

  logic signed [ACC_W-1:0] aa_r, ae_r, ee_r, adr_r, edr_r;
  logic signed [MUL_W-1:0] ad_r, ed_r;
  logic signed [ACC_W-1:0] c0_r, c1_r, c2_r;
  logic [TW-1:0]           t_r;
  logic signed [ACC_W-1:0] x_r;
  logic [ACC_W-1:0]        lo_r;
  logic signed [ACC_W-1:0] d2_r;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod_r;
  logic signed [ACC_W-1:0]   p64;
  logic                      pv_r;
  dot_term_t                 ptag_r;
  dot_term_t                 ti_r;
  logic [1:0]                ci_r;
  logic                      iss_done_r;
  logic                      dot_issue;
  logic [2:0]                step_r;

  logic [ACC_W-1:0]        mag;
  logic [ACC_W-1:0]        mt_mag;
  logic signed [ACC_W-1:0] mt;

  logic [ACC_W-1:0]        c2_mag;
  logic [ACC_W-1:0]        d_val;
  logic signed [ACC_W-1:0] n_val;
  logic signed [ACC_W-1:0] tol_s;
  logic                    tol_hit;
  logic                    go_div;
  logic [TW-1:0]           t_quick;

  logic [SQ_W-1:0] cand;
  logic [SQ_W-1:0] best_nxt;

  logic             in_acc;
  logic             out_acc;
  logic             out_free;
  logic             out_valid_r;
  rlmd_out_t        out_data_r;
  unit_ctl_t        uctl;
  unit_sts_t        usts;
  logic [ACC_W-1:0] uop_a;
  logic [ACC_W-1:0] uop_b;
  logic [ACC_W-1:0] ures;

  rlmd_divsqrt #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_divsqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (uctl),
    .op_a (uop_a),
    .op_b (uop_b),
    .sts  (usts),
    .res  (ures)
  );

  assign vin[0] = in_data.vx;
  assign vin[1] = in_data.vy;
  assign vin[2] = in_data.vz;

  // quadratic decision: degenerate, clamped or needs the divider
  always_comb begin
    c2_mag  = c2_r[ACC_W-1] ? ACC_W'(-c2_r) : ACC_W'(c2_r);
    d_val   = {c2_mag[ACC_W-2:0], 1'b0};
    n_val   = (c2_r > 0) ? -c1_r : c1_r;
    tol_s   = $signed({{(ACC_W-TOL_W){1'b0}}, tol_r});
    tol_hit = (c2_r <= tol_s) && (c2_r >= -tol_s);
    go_div  = 1'b0;
    t_quick = '0;
    if (tol_hit) begin
      if (c1_r < 0) t_quick = T_ONE;
    end else if (n_val <= 0) begin
      t_quick = '0;
    end else if (ACC_W'(n_val) >= d_val) begin
      t_quick = T_ONE;
    end else begin
      go_div = 1'b1;
    end
  end

  // x * t / 2^T, truncated toward zero, from two half-word products
  always_comb begin
    p64    = prod_r[ACC_W-1:0];
    mag    = x_r[ACC_W-1] ? ACC_W'(-x_r) : ACC_W'(x_r);
    mt_mag = (ACC_W'(prod_r[ACC_W-1:0]) << (HALF_W - T_FRAC_BITS)) + (lo_r >> T_FRAC_BITS);
    mt     = x_r[ACC_W-1] ? -$signed(mt_mag) : $signed(mt_mag);
  end

  always_comb begin
    if (d2_r < 0) cand = '0;
    else if (d2_r > SQ_MAX) cand = SQ_MAX[SQ_W-1:0];
    else cand = d2_r[SQ_W-1:0];
    best_nxt = (!have_best_r || (cand < best_r)) ? cand : best_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (have_prev_r || in_data.ring_last)) state_nxt = ST_VEC;
      end
      ST_VEC: state_nxt = ST_DOT;
      ST_DOT: begin
        if (iss_done_r && !pv_r) state_nxt = ST_RND;
      end
      ST_RND: state_nxt = ST_QUAD;
      ST_QUAD: begin
        if (step_r == 3'd3) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: state_nxt = go_div ? ST_DIV : ST_EVAL;
      ST_DIV: begin
        if (usts.done) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (step_r == 3'd5) state_nxt = ST_TAKE;
      end
      ST_TAKE: begin
        if (close_r) state_nxt = ST_VEC;
        else if (last_r) state_nxt = ST_SQRT;
        else state_nxt = ST_IDLE;
      end
      ST_SQRT: begin
        if (usts.done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and operand selection
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    in_acc    = in_valid && !in_stall;
    out_acc   = out_valid_r && !out_stall;
    out_free  = !out_valid_r || !out_stall;
    dot_issue = (state_r == ST_DOT) && !iss_done_r;
    uctl      = '{start: 1'b0, mode: UM_DIV};
    uop_a     = ACC_W'(n_val);
    uop_b     = d_val;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      ST_DOT: begin
        case (ti_r)
          DT_AA: begin
            mul_a = MUL_W'(a_r[ci_r]);
            mul_b = MUL_W'(a_r[ci_r]);
          end
          DT_AE: begin
            mul_a = MUL_W'(a_r[ci_r]);
            mul_b = MUL_W'(e_r[ci_r]);
          end
          DT_EE: begin
            mul_a = MUL_W'(e_r[ci_r]);
            mul_b = MUL_W'(e_r[ci_r]);
          end
          DT_ADR: begin
            mul_a = MUL_W'(a_r[ci_r]);
            mul_b = MUL_W'(dir_r[ci_r]);
          end
          DT_EDR: begin
            mul_a = MUL_W'(e_r[ci_r]);
            mul_b = MUL_W'(dir_r[ci_r]);
          end
          default: ;
        endcase
      end
      ST_QUAD: begin
        mul_a = (step_r == 3'd2) ? ed_r : ad_r;
        mul_b = (step_r == 3'd0) ? ad_r : ed_r;
      end
      ST_EVAL: begin
        if (step_r == 3'd1 || step_r == 3'd4) begin
          mul_a = $signed({2'b00, mag[ACC_W-1:HALF_W]});
        end else begin
          mul_a = $signed({2'b00, mag[HALF_W-1:0]});
        end
        mul_b = $signed({{(MUL_W-TW){1'b0}}, t_r});
      end
      ST_DECIDE: begin
        uctl.start = go_div;
      end
      ST_TAKE: begin
        uctl  = '{start: !close_r && last_r, mode: UM_SQRT};
        uop_a = ACC_W'(best_nxt);
      end
      default: ;
    endcase
    out_valid = out_valid_r;
    out_data  = out_data_r;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      have_prev_r <= 1'b0;
      have_best_r <= 1'b0;
      last_r      <= 1'b0;
      close_r     <= 1'b0;
      pv_r        <= 1'b0;
      iss_done_r  <= 1'b0;
      ci_r        <= '0;
      ti_r        <= DT_AA;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= dot_issue;
      step_r  <= (state_nxt != state_r) ? 3'd0 : step_r + 3'd1;
      if (in_acc) begin
        have_prev_r <= 1'b1;
        last_r      <= in_data.ring_last;
        close_r     <= have_prev_r && in_data.ring_last;
      end
      if (state_r == ST_VEC) begin
        iss_done_r <= 1'b0;
        ci_r       <= '0;
        ti_r       <= DT_AA;
      end
      if (dot_issue) begin
        if (ci_r == 2'd2) begin
          ci_r <= '0;
          if (ti_r == DT_EDR) iss_done_r <= 1'b1;
          else ti_r <= dot_term_t'(ti_r + 3'd1);
        end else begin
          ci_r <= ci_r + 2'd1;
        end
      end
      if (state_r == ST_TAKE) begin
        have_best_r <= 1'b1;
        close_r     <= 1'b0;
      end
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
        have_prev_r <= 1'b0;
        have_best_r <= 1'b0;
        last_r      <= 1'b0;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0] <= '0;
      org_r[1] <= '0;
      org_r[2] <= '0;
      dir_r[0] <= DIR_X_RST;
      dir_r[1] <= '0;
      dir_r[2] <= '0;
      tol_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ORIGIN_X: org_r[0] <= cfg_wdata[COORD_W-1:0];
        CFG_ORIGIN_Y: org_r[1] <= cfg_wdata[COORD_W-1:0];
        CFG_ORIGIN_Z: org_r[2] <= cfg_wdata[COORD_W-1:0];
        CFG_DIR_X:    dir_r[0] <= cfg_wdata[DIR_W-1:0];
        CFG_DIR_Y:    dir_r[1] <= cfg_wdata[DIR_W-1:0];
        CFG_DIR_Z:    dir_r[2] <= cfg_wdata[DIR_W-1:0];
        CFG_ZERO_TOL: tol_r    <= cfg_wdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    ptag_r <= ti_r;
    if (in_acc) begin
      for (int i = 0; i < 3; i++) begin
        prev_r[i] <= vin[i];
        if (!have_prev_r) first_r[i] <= vin[i];
        p0_r[i] <= have_prev_r ? prev_r[i] : vin[i];
        p1_r[i] <= vin[i];
      end
    end
    case (state_r)
      ST_VEC: begin
        for (int i = 0; i < 3; i++) begin
          a_r[i] <= sat_vec($signed({p0_r[i][COORD_W-1], p0_r[i]})
                            - $signed({org_r[i][COORD_W-1], org_r[i]}));
          e_r[i] <= sat_vec($signed({p1_r[i][COORD_W-1], p1_r[i]})
                            - $signed({p0_r[i][COORD_W-1], p0_r[i]}));
        end
        aa_r  <= '0;
        ae_r  <= '0;
        ee_r  <= '0;
        adr_r <= '0;
        edr_r <= '0;
      end
      ST_DOT: begin
        if (pv_r) begin
          case (ptag_r)
            DT_AA:   aa_r  <= aa_r + p64;
            DT_AE:   ae_r  <= ae_r + p64;
            DT_EE:   ee_r  <= ee_r + p64;
            DT_ADR:  adr_r <= adr_r + p64;
            DT_EDR:  edr_r <= edr_r + p64;
            default: ;
          endcase
        end
      end
      ST_RND: begin
        ad_r <= round_dir(adr_r);
        ed_r <= round_dir(edr_r);
      end
      ST_QUAD: begin
        if (step_r == 3'd1) c0_r <= aa_r - p64;
        if (step_r == 3'd2) c1_r <= (ae_r - p64) <<< 1;
        if (step_r == 3'd3) c2_r <= ee_r - p64;
      end
      ST_DECIDE: begin
        x_r <= c2_r;
        t_r <= t_quick;
      end
      ST_DIV: begin
        if (usts.done) t_r <= {1'b0, ures[T_FRAC_BITS-1:0]};
      end
      ST_EVAL: begin
        if (step_r == 3'd1 || step_r == 3'd4) lo_r <= prod_r[ACC_W-1:0];
        if (step_r == 3'd2) x_r <= c1_r + mt;
        if (step_r == 3'd5) d2_r <= c0_r + mt;
      end
      ST_TAKE: begin
        best_r <= best_nxt;
        for (int i = 0; i < 3; i++) begin
          p0_r[i] <= prev_r[i];
          p1_r[i] <= first_r[i];
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_data_r.min_dist_sq <= best_r;
          out_data_r.min_dist    <= ures[ROOT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  `RLMD_ASSERT(a_done_wait, usts.done |-> (state_r == ST_DIV || state_r == ST_SQRT), "unit finished outside a wait state")
  `RLMD_ASSERT(a_start_free, uctl.start |-> !usts.busy, "unit started while busy")
  `RLMD_ASSERT(a_best_prev, have_best_r |-> have_prev_r, "minimum held without a vertex")
  `RLMD_ASSERT_NEXT(a_out_load, state_r == ST_OUT && !out_valid_r, out_valid_r, "result not loaded")

endmodule
